FILE: hdl/karl_pkg.sv
// Package: shared constants, codes and types of the key auto-release timer table.
`default_nettype none
package karl_pkg;

   localparam int SLOTS_DEF = 16;
   localparam int MAX_RES   = 32;
   localparam int RES_W     = $clog2(MAX_RES + 1);
   localparam int CNT_W     = 9;
   localparam int ROW_W     = 3;
   localparam int COL_W     = 3;
   localparam int CODE_W    = 32;
   localparam int MODS_W    = 16;
   localparam int MAT_DW    = ROW_W + COL_W;
   localparam int CODE_DW   = CODE_W + MODS_W;
   localparam int REQ_DW    = 64;
   localparam int RSP_DW    = 56;

   // func selector on the request side
   typedef enum logic [1:0] {
      FN_TICK       = 2'd0,
      FN_SCHED_MAT  = 2'd1,
      FN_SCHED_CODE = 2'd2,
      FN_NONE       = 2'd3
   } func_type;

   // event kind on the response side
   typedef enum logic [1:0] {
      EV_SCHED    = 2'd0,
      EV_REFUSED  = 2'd1,
      EV_MAT_REL  = 2'd2,
      EV_CODE_REL = 2'd3
   } event_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCHED,
      ST_SRESP,
      ST_SCAN_MAT,
      ST_SCAN_CODE,
      ST_FINISH
   } state_type;

   // control part of one timer slot
   typedef struct packed {
      logic             valid;
      logic [CNT_W-1:0] count;
   } slot_ctl_type;

endpackage
`default_nettype wire

FILE: hdl/karl_cell.sv
// One timer slot cell: holds valid, count and key payload, loads from its neighbor on shift.
`default_nettype none
module karl_cell #(
   parameter int DW = karl_pkg::MAT_DW
) (
   input  wire                          clock,
   input  wire                          reset,
   input  wire                          shift_en,
   input  wire karl_pkg::slot_ctl_type  ctl_in,
   input  wire [DW-1:0]                 data_in,
   output karl_pkg::slot_ctl_type       ctl_out,
   output logic [DW-1:0]                data_out
);

   karl_pkg::slot_ctl_type ctl_ff;
   logic [DW-1:0]          data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_ff <= '0;
      end else if (shift_en) begin
         ctl_ff <= ctl_in;
      end
   end

   always_ff @(posedge clock) begin
      if (shift_en) begin
         data_ff <= data_in;
      end
   end

   assign ctl_out  = ctl_ff;
   assign data_out = data_ff;

endmodule
`default_nettype wire

FILE: hdl/karl_ring.sv
// Ring of timer cells: slot 0 sits at the head, the processed head word re-enters at the tail.
`default_nettype none
module karl_ring #(
   parameter int SLOTS = karl_pkg::SLOTS_DEF,
   parameter int DW    = karl_pkg::MAT_DW
) (
   input  wire                          clock,
   input  wire                          reset,
   input  wire                          shift_en,
   input  wire karl_pkg::slot_ctl_type  fb_ctl,
   input  wire [DW-1:0]                 fb_data,
   output karl_pkg::slot_ctl_type       head_ctl,
   output logic [DW-1:0]                head_data
);

   karl_pkg::slot_ctl_type ctl_q  [SLOTS];
   logic [DW-1:0]          data_q [SLOTS];

   for (genvar k = 0; k < SLOTS; k++) begin : g_cell
      karl_pkg::slot_ctl_type nxt_ctl;
      logic [DW-1:0]          nxt_data;

      if (k == SLOTS - 1) begin : g_tail
         assign nxt_ctl  = fb_ctl;
         assign nxt_data = fb_data;
      end else begin : g_mid
         assign nxt_ctl  = ctl_q[k+1];
         assign nxt_data = data_q[k+1];
      end

      karl_cell #(.DW(DW)) u_cell (
         .clock    (clock),
         .reset    (reset),
         .shift_en (shift_en),
         .ctl_in   (nxt_ctl),
         .data_in  (nxt_data),
         .ctl_out  (ctl_q[k]),
         .data_out (data_q[k])
      );
   end

   assign head_ctl  = ctl_q[0];
   assign head_data = data_q[0];

endmodule
`default_nettype wire

FILE: hdl/key_auto_release_timer_table_top.sv
// Top level of the key auto-release timer table: sequencer, result staging and two slot rings.
`default_nettype none
// Two tables of SLOTS one-shot key release timers (matrix keys and host key codes), each a ring
// of cells that rotates one slot per cycle past a single head processor, unless the response
// side stalls a release. A schedule word takes one ring revolution, then the accept/refuse word;
// a tick takes a revolution of the matrix ring, then of the code ring, then the final release.
// Releases of a tick are staged one word behind so the last one carries tlast; a tick that
// frees nothing sends no word. The tables are empty after reset.
module key_auto_release_timer_table_top #(
   parameter int SLOTS = karl_pkg::SLOTS_DEF
) (
   input  wire                          clock,
   input  wire                          reset,
   input  wire                          req_tvalid,
   output logic                         req_tready,
   // [2:0] key_row, [5:3] key_col, [37:6] code_in, [53:38] mods_in, [62:54] release_frames
   input  wire [karl_pkg::REQ_DW-1:0]   req_tdata,
   // [1:0] func
   input  wire [1:0]                    req_tuser,
   output logic                         rsp_tvalid,
   input  wire                          rsp_tready,
   // [2:0] rel_row, [5:3] rel_col, [37:6] rel_code, [53:38] rel_mods, [55:54] zero
   output logic [karl_pkg::RSP_DW-1:0]  rsp_tdata,
   // [1:0] event_res
   output logic [1:0]                   rsp_tuser,
   output logic                         rsp_tlast
);

   localparam int CW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
   localparam int ROW_W  = karl_pkg::ROW_W;
   localparam int COL_W  = karl_pkg::COL_W;
   localparam int CODE_W = karl_pkg::CODE_W;
   localparam int MODS_W = karl_pkg::MODS_W;
   localparam int CNT_W  = karl_pkg::CNT_W;
   localparam int RES_W  = karl_pkg::RES_W;

   karl_pkg::state_type state_ff, state_in;
   logic [CW-1:0]       cnt_ff, cnt_in;
   logic [RES_W-1:0]    res_n_ff, res_n_in;
   logic                found_ff, found_in;
   logic                sched_code_ff, sched_code_in;

   // latched schedule word
   logic [ROW_W-1:0]    new_row_ff, new_row_in;
   logic [COL_W-1:0]    new_col_ff, new_col_in;
   logic [CODE_W-1:0]   new_code_ff, new_code_in;
   logic [MODS_W-1:0]   new_mods_ff, new_mods_in;
   logic [CNT_W-1:0]    new_cnt_ff, new_cnt_in;

   // pending release, held back one word to know tlast
   logic                pend_valid_ff, pend_valid_in;
   karl_pkg::event_type pend_kind_ff, pend_kind_in;
   logic [ROW_W-1:0]    pend_row_ff, pend_row_in;
   logic [COL_W-1:0]    pend_col_ff, pend_col_in;
   logic [CODE_W-1:0]   pend_code_ff, pend_code_in;
   logic [MODS_W-1:0]   pend_mods_ff, pend_mods_in;

   // output register
   logic                rsp_valid_ff, rsp_valid_in;
   karl_pkg::event_type rsp_kind_ff, rsp_kind_in;
   logic [ROW_W-1:0]    rsp_row_ff, rsp_row_in;
   logic [COL_W-1:0]    rsp_col_ff, rsp_col_in;
   logic [CODE_W-1:0]   rsp_code_ff, rsp_code_in;
   logic [MODS_W-1:0]   rsp_mods_ff, rsp_mods_in;
   logic                rsp_last_ff, rsp_last_in;

   logic                         mat_shift, code_shift;
   karl_pkg::slot_ctl_type       mat_head_ctl, code_head_ctl, mat_fb_ctl, code_fb_ctl;
   logic [karl_pkg::MAT_DW-1:0]  mat_head_data, mat_fb_data;
   logic [karl_pkg::CODE_DW-1:0] code_head_data, code_fb_data;

   karl_pkg::slot_ctl_type hd_ctl, upd_ctl;
   logic                   out_free, last_step, expired, rel, adv;
   logic [CNT_W-1:0]       req_hold;

   karl_ring #(.SLOTS(SLOTS), .DW(karl_pkg::MAT_DW)) u_mat_ring (
      .clock     (clock),
      .reset     (reset),
      .shift_en  (mat_shift),
      .fb_ctl    (mat_fb_ctl),
      .fb_data   (mat_fb_data),
      .head_ctl  (mat_head_ctl),
      .head_data (mat_head_data)
   );

   karl_ring #(.SLOTS(SLOTS), .DW(karl_pkg::CODE_DW)) u_code_ring (
      .clock     (clock),
      .reset     (reset),
      .shift_en  (code_shift),
      .fb_ctl    (code_fb_ctl),
      .fb_data   (code_fb_data),
      .head_ctl  (code_head_ctl),
      .head_data (code_head_data)
   );

   assign req_tready = (state_ff == karl_pkg::ST_IDLE);
   assign req_hold   = req_tdata[62:54];

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_kind_ff;
   assign rsp_tlast  = rsp_last_ff;
   assign rsp_tdata  = {2'b00, rsp_mods_ff, rsp_code_ff, rsp_col_ff, rsp_row_ff};

   always_comb begin
      hd_ctl    = (state_ff == karl_pkg::ST_SCAN_CODE) ? code_head_ctl : mat_head_ctl;
      out_free  = !rsp_valid_ff || rsp_tready;
      last_step = (cnt_ff == CW'(SLOTS - 1));
      expired   = hd_ctl.valid && (hd_ctl.count[CNT_W-1:1] == '0);
      rel       = expired && (res_n_ff < RES_W'(karl_pkg::MAX_RES));
      adv       = !(rel && pend_valid_ff && !out_free);

      // head slot after a tick
      upd_ctl = hd_ctl;
      if (hd_ctl.valid) begin
         if (expired) begin
            upd_ctl.valid = !rel;
            upd_ctl.count = '0;
         end else begin
            upd_ctl.count = hd_ctl.count - CNT_W'(1);
         end
      end
   end

   always_comb begin
      state_in      = state_ff;
      cnt_in        = cnt_ff;
      res_n_in      = res_n_ff;
      found_in      = found_ff;
      sched_code_in = sched_code_ff;
      new_row_in    = new_row_ff;
      new_col_in    = new_col_ff;
      new_code_in   = new_code_ff;
      new_mods_in   = new_mods_ff;
      new_cnt_in    = new_cnt_ff;
      pend_valid_in = pend_valid_ff;
      pend_kind_in  = pend_kind_ff;
      pend_row_in   = pend_row_ff;
      pend_col_in   = pend_col_ff;
      pend_code_in  = pend_code_ff;
      pend_mods_in  = pend_mods_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_kind_in   = rsp_kind_ff;
      rsp_row_in    = rsp_row_ff;
      rsp_col_in    = rsp_col_ff;
      rsp_code_in   = rsp_code_ff;
      rsp_mods_in   = rsp_mods_ff;
      rsp_last_in   = rsp_last_ff;
      mat_shift     = 1'b0;
      code_shift    = 1'b0;
      mat_fb_ctl    = mat_head_ctl;
      mat_fb_data   = mat_head_data;
      code_fb_ctl   = code_head_ctl;
      code_fb_data  = code_head_data;

      unique case (state_ff)
         karl_pkg::ST_IDLE: begin
            if (req_tvalid) begin
               new_row_in  = req_tdata[2:0];
               new_col_in  = req_tdata[5:3];
               new_code_in = req_tdata[37:6];
               new_mods_in = req_tdata[53:38];
               new_cnt_in  = (req_hold == '0) ? CNT_W'(1) : req_hold;
               cnt_in      = '0;
               found_in    = 1'b0;
               res_n_in    = '0;
               case (karl_pkg::func_type'(req_tuser))
                  karl_pkg::FN_TICK: state_in = karl_pkg::ST_SCAN_MAT;
                  karl_pkg::FN_SCHED_MAT: begin
                     sched_code_in = 1'b0;
                     state_in      = karl_pkg::ST_SCHED;
                  end
                  karl_pkg::FN_SCHED_CODE: begin
                     sched_code_in = 1'b1;
                     state_in      = karl_pkg::ST_SCHED;
                  end
                  default: state_in = karl_pkg::ST_IDLE;
               endcase
            end
         end

         karl_pkg::ST_SCHED: begin
            mat_shift  = !sched_code_ff;
            code_shift = sched_code_ff;
            if (!sched_code_ff && !mat_head_ctl.valid && !found_ff) begin
               mat_fb_ctl  = '{valid: 1'b1, count: new_cnt_ff};
               mat_fb_data = {new_col_ff, new_row_ff};
               found_in    = 1'b1;
            end
            if (sched_code_ff && !code_head_ctl.valid && !found_ff) begin
               code_fb_ctl  = '{valid: 1'b1, count: new_cnt_ff};
               code_fb_data = {new_mods_ff, new_code_ff};
               found_in     = 1'b1;
            end
            cnt_in = cnt_ff + CW'(1);
            if (last_step) begin
               cnt_in   = '0;
               state_in = karl_pkg::ST_SRESP;
            end
         end

         karl_pkg::ST_SRESP: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_kind_in  = found_ff ? karl_pkg::EV_SCHED : karl_pkg::EV_REFUSED;
               rsp_row_in   = '0;
               rsp_col_in   = '0;
               rsp_code_in  = '0;
               rsp_mods_in  = '0;
               rsp_last_in  = 1'b1;
               state_in     = karl_pkg::ST_IDLE;
            end
         end

         karl_pkg::ST_SCAN_MAT, karl_pkg::ST_SCAN_CODE: begin
            if (adv) begin
               if (state_ff == karl_pkg::ST_SCAN_MAT) begin
                  mat_shift  = 1'b1;
                  mat_fb_ctl = upd_ctl;
               end else begin
                  code_shift  = 1'b1;
                  code_fb_ctl = upd_ctl;
               end
               if (rel) begin
                  // previous release goes out, not last
                  if (pend_valid_ff) begin
                     rsp_valid_in = 1'b1;
                     rsp_kind_in  = pend_kind_ff;
                     rsp_row_in   = pend_row_ff;
                     rsp_col_in   = pend_col_ff;
                     rsp_code_in  = pend_code_ff;
                     rsp_mods_in  = pend_mods_ff;
                     rsp_last_in  = 1'b0;
                  end
                  pend_valid_in = 1'b1;
                  res_n_in      = res_n_ff + RES_W'(1);
                  if (state_ff == karl_pkg::ST_SCAN_MAT) begin
                     pend_kind_in = karl_pkg::EV_MAT_REL;
                     pend_row_in  = mat_head_data[ROW_W-1:0];
                     pend_col_in  = mat_head_data[ROW_W+COL_W-1:ROW_W];
                     pend_code_in = '0;
                     pend_mods_in = '0;
                  end else begin
                     pend_kind_in = karl_pkg::EV_CODE_REL;
                     pend_row_in  = '0;
                     pend_col_in  = '0;
                     pend_code_in = code_head_data[CODE_W-1:0];
                     pend_mods_in = code_head_data[CODE_W+MODS_W-1:CODE_W];
                  end
               end
               cnt_in = cnt_ff + CW'(1);
               if (last_step) begin
                  cnt_in   = '0;
                  state_in = (state_ff == karl_pkg::ST_SCAN_MAT) ?
                             karl_pkg::ST_SCAN_CODE : karl_pkg::ST_FINISH;
               end
            end
         end

         karl_pkg::ST_FINISH: begin
            if (!pend_valid_ff) begin
               state_in = karl_pkg::ST_IDLE;
            end else if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_kind_in   = pend_kind_ff;
               rsp_row_in    = pend_row_ff;
               rsp_col_in    = pend_col_ff;
               rsp_code_in   = pend_code_ff;
               rsp_mods_in   = pend_mods_ff;
               rsp_last_in   = 1'b1;
               pend_valid_in = 1'b0;
               state_in      = karl_pkg::ST_IDLE;
            end
         end

         default: state_in = karl_pkg::ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= karl_pkg::ST_IDLE;
         cnt_ff        <= '0;
         res_n_ff      <= '0;
         found_ff      <= 1'b0;
         sched_code_ff <= 1'b0;
         pend_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         cnt_ff        <= cnt_in;
         res_n_ff      <= res_n_in;
         found_ff      <= found_in;
         sched_code_ff <= sched_code_in;
         pend_valid_ff <= pend_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      new_row_ff   <= new_row_in;
      new_col_ff   <= new_col_in;
      new_code_ff  <= new_code_in;
      new_mods_ff  <= new_mods_in;
      new_cnt_ff   <= new_cnt_in;
      pend_kind_ff <= pend_kind_in;
      pend_row_ff  <= pend_row_in;
      pend_col_ff  <= pend_col_in;
      pend_code_ff <= pend_code_in;
      pend_mods_ff <= pend_mods_in;
      rsp_kind_ff  <= rsp_kind_in;
      rsp_row_ff   <= rsp_row_in;
      rsp_col_ff   <= rsp_col_in;
      rsp_code_ff  <= rsp_code_in;
      rsp_mods_ff  <= rsp_mods_in;
      rsp_last_ff  <= rsp_last_in;
   end

`ifndef NO_ASSERTIONS
   // nothing stays staged once the sequencer is back to idle
   a_pend_idle: assert property (@(posedge clock) disable iff (reset)
      state_ff == karl_pkg::ST_IDLE |-> !pend_valid_ff)
      else $error("pending release left over in idle");

   // schedules never stage a release
   a_pend_sched: assert property (@(posedge clock) disable iff (reset)
      (state_ff == karl_pkg::ST_SCHED || state_ff == karl_pkg::ST_SRESP) |-> !pend_valid_ff)
      else $error("pending release during schedule");

   // only release words may go out without tlast
   a_nonlast_kind: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_last_ff |->
         (rsp_kind_ff == karl_pkg::EV_MAT_REL || rsp_kind_ff == karl_pkg::EV_CODE_REL))
      else $error("non-release word without tlast");

   // release count per tick stays within the limit
   a_res_limit: assert property (@(posedge clock) disable iff (reset)
      res_n_ff <= RES_W'(karl_pkg::MAX_RES))
      else $error("release count over limit");

   // a stall on a release holds the rings still
   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      (state_ff == karl_pkg::ST_SCAN_MAT || state_ff == karl_pkg::ST_SCAN_CODE) && !adv
         |-> !mat_shift && !code_shift)
      else $error("ring moved while stalled");
`endif

endmodule
`default_nettype wire
